// ===== rtl/core/cec_pkg.sv =====
package cec_pkg;

    localparam int K_STEPS   = 21;
    localparam int S_STEPS   = 16;

    localparam logic signed [23:0] SAT_HI = 24'sd32767;
    localparam logic signed [23:0] SAT_LO = -24'sd32768;

    typedef struct packed {
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic signed [15:0] vx1;
        logic signed [15:0] vy1;
        logic signed [15:0] x2;
        logic signed [15:0] y2;
        logic signed [15:0] vx2;
        logic signed [15:0] vy2;
    } base_t;

    typedef struct packed {
        base_t        base;
        logic         hit;
        logic         dxn;
        logic         dyn;
        logic [12:0]  mx;
        logic [12:0]  my;
        logic [12:0]  rs;
        logic [25:0]  d2;
        logic [25:0]  kx_rem;
        logic [25:0]  ky_rem;
        logic [20:0]  kx_sh;
        logic [20:0]  ky_sh;
        logic [20:0]  kx_q;
        logic [20:0]  ky_q;
        logic [22:0]  sq_rem;
        logic [20:0]  sq_res;
        logic [41:0]  sq_sh;
    } iter_t;

    typedef struct packed {
        base_t        base;
        logic         hit;
        logic         dxn;
        logic         dyn;
        logic [20:0]  kx_q;
        logic [20:0]  ky_q;
        logic [21:0]  den;
        logic [21:0]  sx_rem;
        logic [21:0]  sy_rem;
        logic [15:0]  sx_sh;
        logic [15:0]  sy_sh;
        logic [15:0]  sx_q;
        logic [15:0]  sy_q;
    } sep_t;

    // One restoring division step; the upper bit of the result is the quotient bit.
    function automatic logic [26:0] div_step(input logic [25:0] rem, input logic nb,
                                             input logic [25:0] dvs);
        logic [26:0] r;
        logic [26:0] t;
        r = {rem, nb};
        t = r - {1'b0, dvs};
        if (r >= {1'b0, dvs})
            return {1'b1, t[25:0]};
        else
            return {1'b0, r[25:0]};
    endfunction

    function automatic logic [15:0] sat(input logic signed [23:0] v);
        if (v > SAT_HI)
            return 16'h7fff;
        else if (v < SAT_LO)
            return 16'h8000;
        else
            return v[15:0];
    endfunction

endpackage

// ===== rtl/core/circle_elastic_collision.sv =====
// Channel  Handshake                    Payload
// input    valid / stall                first_* and second_* circle fields
// result   result_valid / result_stall  collided and out_* fields
//
// One beat is taken every cycle while stall is low; from the edge that accepted its
// input, each result passes through 43 register stages: four front stages, 21 root and
// impulse division stages, one separation setup stage, 16 separation division stages
// and the output stage. Each division or root stage resolves one bit.
// Reset clears every stage valid bit; the data registers are not reset.
// While a result waits under result_stall, the whole pipeline holds and stall is raised.
module circle_elastic_collision (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               stall,
    input  logic signed [15:0] first_x,
    input  logic signed [15:0] first_y,
    input  logic signed [15:0] first_vx,
    input  logic signed [15:0] first_vy,
    input  logic [11:0]        first_radius,
    input  logic signed [15:0] second_x,
    input  logic signed [15:0] second_y,
    input  logic signed [15:0] second_vx,
    input  logic signed [15:0] second_vy,
    input  logic [11:0]        second_radius,
    output logic               result_valid,
    input  logic               result_stall,
    output logic               collided,
    output logic signed [15:0] out_first_x,
    output logic signed [15:0] out_first_y,
    output logic signed [15:0] out_first_vx,
    output logic signed [15:0] out_first_vy,
    output logic signed [15:0] out_second_x,
    output logic signed [15:0] out_second_y,
    output logic signed [15:0] out_second_vx,
    output logic signed [15:0] out_second_vy
);

    logic                  en;
    logic [cec_pkg::K_STEPS:0] iter_valid;
    cec_pkg::iter_t        iter_data [0:cec_pkg::K_STEPS];
    logic [cec_pkg::S_STEPS:0] sep_valid;
    cec_pkg::sep_t         sep_data [0:cec_pkg::S_STEPS];

    assign en    = !(result_valid && result_stall);
    assign stall = !en;

    cec_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (valid),
        .first_x       (first_x),
        .first_y       (first_y),
        .first_vx      (first_vx),
        .first_vy      (first_vy),
        .first_radius  (first_radius),
        .second_x      (second_x),
        .second_y      (second_y),
        .second_vx     (second_vx),
        .second_vy     (second_vy),
        .second_radius (second_radius),
        .out_valid     (iter_valid[0]),
        .out_data      (iter_data[0])
    );

    for (genvar i = 0; i < cec_pkg::K_STEPS; i++)
    begin : g_iter
        cec_iter_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (iter_valid[i]),
            .in_data   (iter_data[i]),
            .out_valid (iter_valid[i+1]),
            .out_data  (iter_data[i+1])
        );
    end

    cec_sep_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (iter_valid[cec_pkg::K_STEPS]),
        .in_data   (iter_data[cec_pkg::K_STEPS]),
        .out_valid (sep_valid[0]),
        .out_data  (sep_data[0])
    );

    for (genvar j = 0; j < cec_pkg::S_STEPS; j++)
    begin : g_sep
        cec_sep_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sep_valid[j]),
            .in_data   (sep_data[j]),
            .out_valid (sep_valid[j+1]),
            .out_data  (sep_data[j+1])
        );
    end

    cec_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sep_valid[cec_pkg::S_STEPS]),
        .in_data   (sep_data[cec_pkg::S_STEPS]),
        .out_valid (result_valid),
        .collided  (collided),
        .o_x1      (out_first_x),
        .o_y1      (out_first_y),
        .o_vx1     (out_first_vx),
        .o_vy1     (out_first_vy),
        .o_x2      (out_second_x),
        .o_y2      (out_second_y),
        .o_vx2     (out_second_vx),
        .o_vy2     (out_second_vy)
    );

endmodule

// ===== rtl/core/cec_front.sv =====
module cec_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [15:0] first_x,
    input  logic signed [15:0] first_y,
    input  logic signed [15:0] first_vx,
    input  logic signed [15:0] first_vy,
    input  logic [11:0]        first_radius,
    input  logic signed [15:0] second_x,
    input  logic signed [15:0] second_y,
    input  logic signed [15:0] second_vx,
    input  logic signed [15:0] second_vy,
    input  logic [11:0]        second_radius,
    output logic               out_valid,
    output cec_pkg::iter_t     out_data
);

    typedef struct packed {
        cec_pkg::base_t     base;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [16:0] dvx;
        logic signed [16:0] dvy;
        logic [12:0]        rs;
    } s1_t;

    typedef struct packed {
        cec_pkg::base_t     base;
        logic               dxn;
        logic               dyn;
        logic [15:0]        mx;
        logic [15:0]        my;
        logic [12:0]        rs;
        logic [31:0]        sqx;
        logic [31:0]        sqy;
        logic [25:0]        rs2;
        logic signed [33:0] px;
        logic signed [33:0] py;
    } s2_t;

    typedef struct packed {
        cec_pkg::base_t base;
        logic           hit;
        logic           dxn;
        logic           dyn;
        logic [12:0]    mx;
        logic [12:0]    my;
        logic [12:0]    rs;
        logic [25:0]    d2;
        logic [30:0]    adot;
    } s3_t;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    cec_pkg::iter_t s4_reg, s4_next;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [16:0] ndx, ndy;
    logic [32:0]        d2;
    logic signed [34:0] dot, ndot;
    logic [43:0]        pkx, pky;
    logic [44:0]        nkx, nky;

    always_comb
    begin
        s1_next.base.x1  = first_x;
        s1_next.base.y1  = first_y;
        s1_next.base.vx1 = first_vx;
        s1_next.base.vy1 = first_vy;
        s1_next.base.x2  = second_x;
        s1_next.base.y2  = second_y;
        s1_next.base.vx2 = second_vx;
        s1_next.base.vy2 = second_vy;
        s1_next.dx  = $signed({second_x[15], second_x}) - $signed({first_x[15], first_x});
        s1_next.dy  = $signed({second_y[15], second_y}) - $signed({first_y[15], first_y});
        s1_next.dvx = $signed({second_vx[15], second_vx}) - $signed({first_vx[15], first_vx});
        s1_next.dvy = $signed({second_vy[15], second_vy}) - $signed({first_vy[15], first_vy});
        s1_next.rs  = {1'b0, first_radius} + {1'b0, second_radius};
    end

    assign ndx = -s1_reg.dx;
    assign ndy = -s1_reg.dy;

    always_comb
    begin
        s2_next.base = s1_reg.base;
        s2_next.dxn  = s1_reg.dx[16];
        s2_next.dyn  = s1_reg.dy[16];
        s2_next.mx   = s1_reg.dx[16] ? ndx[15:0] : s1_reg.dx[15:0];
        s2_next.my   = s1_reg.dy[16] ? ndy[15:0] : s1_reg.dy[15:0];
        s2_next.rs   = s1_reg.rs;
        s2_next.sqx  = s2_next.mx * s2_next.mx;
        s2_next.sqy  = s2_next.my * s2_next.my;
        s2_next.rs2  = s1_reg.rs * s1_reg.rs;
        s2_next.px   = $signed(s1_reg.dvx) * $signed(s1_reg.dx);
        s2_next.py   = $signed(s1_reg.dvy) * $signed(s1_reg.dy);
    end

    assign d2   = {1'b0, s2_reg.sqx} + {1'b0, s2_reg.sqy};
    assign dot  = $signed({s2_reg.px[33], s2_reg.px}) + $signed({s2_reg.py[33], s2_reg.py});
    assign ndot = -dot;

    always_comb
    begin
        s3_next.base = s2_reg.base;
        s3_next.hit  = (d2 != 33'd0) && (d2 <= {7'd0, s2_reg.rs2})
                       && (dot[34] || (dot == 35'sd0));
        s3_next.dxn  = s2_reg.dxn;
        s3_next.dyn  = s2_reg.dyn;
        s3_next.mx   = s2_reg.mx[12:0];
        s3_next.my   = s2_reg.my[12:0];
        s3_next.rs   = s2_reg.rs;
        s3_next.d2   = d2[25:0];
        s3_next.adot = ndot[30:0];
    end

    assign pkx = s3_reg.adot * s3_reg.mx;
    assign pky = s3_reg.adot * s3_reg.my;
    assign nkx = {1'b0, pkx} + {20'd0, s3_reg.d2[25:1]};
    assign nky = {1'b0, pky} + {20'd0, s3_reg.d2[25:1]};

    always_comb
    begin
        s4_next.base   = s3_reg.base;
        s4_next.hit    = s3_reg.hit;
        s4_next.dxn    = s3_reg.dxn;
        s4_next.dyn    = s3_reg.dyn;
        s4_next.mx     = s3_reg.mx;
        s4_next.my     = s3_reg.my;
        s4_next.rs     = s3_reg.rs;
        s4_next.d2     = s3_reg.d2;
        s4_next.kx_rem = {2'd0, nkx[44:21]};
        s4_next.ky_rem = {2'd0, nky[44:21]};
        s4_next.kx_sh  = nkx[20:0];
        s4_next.ky_sh  = nky[20:0];
        s4_next.kx_q   = '0;
        s4_next.ky_q   = '0;
        s4_next.sq_rem = '0;
        s4_next.sq_res = '0;
        s4_next.sq_sh  = {s3_reg.d2, 16'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = s4_reg;

    // A contact never comes from coincident centres.
    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && s3_reg.hit |-> s3_reg.d2 != 26'd0)
        else $error("contact flagged with coincident centres");

    // In contact each axis offset is bounded by the radius sum.
    a_hit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && s3_reg.hit |-> (s3_reg.mx <= s3_reg.rs) && (s3_reg.my <= s3_reg.rs))
        else $error("axis offset exceeds radius sum in contact");

endmodule

// ===== rtl/core/cec_iter_step.sv =====
module cec_iter_step (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  cec_pkg::iter_t in_data,
    output logic           out_valid,
    output cec_pkg::iter_t out_data
);

    cec_pkg::iter_t data_reg, data_next;
    logic           valid_reg;
    logic [26:0]    kx_r, ky_r;
    logic [24:0]    sq_r, sq_t, sq_d;
    logic           sq_ge;

    assign kx_r  = cec_pkg::div_step(in_data.kx_rem, in_data.kx_sh[20], in_data.d2);
    assign ky_r  = cec_pkg::div_step(in_data.ky_rem, in_data.ky_sh[20], in_data.d2);
    assign sq_r  = {in_data.sq_rem, in_data.sq_sh[41:40]};
    assign sq_t  = {2'b00, in_data.sq_res, 2'b01};
    assign sq_ge = sq_r >= sq_t;
    assign sq_d  = sq_r - sq_t;

    always_comb
    begin
        data_next        = in_data;
        data_next.kx_rem = kx_r[25:0];
        data_next.ky_rem = ky_r[25:0];
        data_next.kx_q   = {in_data.kx_q[19:0], kx_r[26]};
        data_next.ky_q   = {in_data.ky_q[19:0], ky_r[26]};
        data_next.kx_sh  = {in_data.kx_sh[19:0], 1'b0};
        data_next.ky_sh  = {in_data.ky_sh[19:0], 1'b0};
        data_next.sq_rem = sq_ge ? sq_d[22:0] : sq_r[22:0];
        data_next.sq_res = {in_data.sq_res[19:0], sq_ge};
        data_next.sq_sh  = {in_data.sq_sh[39:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/cec_sep_prep.sv =====
module cec_sep_prep (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  cec_pkg::iter_t in_data,
    output logic           out_valid,
    output cec_pkg::sep_t  out_data
);

    cec_pkg::sep_t data_reg, data_next;
    logic          valid_reg;
    logic [20:0]   m, diff;
    logic [33:0]   psx, psy;
    logic [34:0]   nsx, nsy;

    assign m    = {in_data.rs, 8'd0};
    assign diff = (m > in_data.sq_res) ? (m - in_data.sq_res) : 21'd0;
    assign psx  = in_data.mx * diff;
    assign psy  = in_data.my * diff;
    assign nsx  = {1'b0, psx} + {14'd0, in_data.sq_res};
    assign nsy  = {1'b0, psy} + {14'd0, in_data.sq_res};

    always_comb
    begin
        data_next.base   = in_data.base;
        data_next.hit    = in_data.hit;
        data_next.dxn    = in_data.dxn;
        data_next.dyn    = in_data.dyn;
        data_next.kx_q   = in_data.kx_q;
        data_next.ky_q   = in_data.ky_q;
        data_next.den    = {in_data.sq_res, 1'b0};
        data_next.sx_rem = {3'd0, nsx[34:16]};
        data_next.sy_rem = {3'd0, nsy[34:16]};
        data_next.sx_sh  = nsx[15:0];
        data_next.sy_sh  = nsy[15:0];
        data_next.sx_q   = '0;
        data_next.sy_q   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // The scaled distance of a contact is at least one unit.
    a_len_min: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_data.hit |-> in_data.sq_res >= 21'd256)
        else $error("distance root too small in contact");

endmodule

// ===== rtl/core/cec_sep_step.sv =====
module cec_sep_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  cec_pkg::sep_t in_data,
    output logic          out_valid,
    output cec_pkg::sep_t out_data
);

    cec_pkg::sep_t data_reg, data_next;
    logic          valid_reg;
    logic [26:0]   sx_r, sy_r;

    assign sx_r = cec_pkg::div_step({4'd0, in_data.sx_rem}, in_data.sx_sh[15],
                                    {4'd0, in_data.den});
    assign sy_r = cec_pkg::div_step({4'd0, in_data.sy_rem}, in_data.sy_sh[15],
                                    {4'd0, in_data.den});

    always_comb
    begin
        data_next        = in_data;
        data_next.sx_rem = sx_r[21:0];
        data_next.sy_rem = sy_r[21:0];
        data_next.sx_q   = {in_data.sx_q[14:0], sx_r[26]};
        data_next.sy_q   = {in_data.sy_q[14:0], sy_r[26]};
        data_next.sx_sh  = {in_data.sx_sh[14:0], 1'b0};
        data_next.sy_sh  = {in_data.sy_sh[14:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/cec_finish.sv =====
module cec_finish (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  cec_pkg::sep_t in_data,
    output logic          out_valid,
    output logic          collided,
    output logic [15:0]   o_x1,
    output logic [15:0]   o_y1,
    output logic [15:0]   o_vx1,
    output logic [15:0]   o_vy1,
    output logic [15:0]   o_x2,
    output logic [15:0]   o_y2,
    output logic [15:0]   o_vx2,
    output logic [15:0]   o_vy2
);

    logic               valid_reg;
    logic               hit_reg;
    logic [15:0]        x1_reg, y1_reg, vx1_reg, vy1_reg;
    logic [15:0]        x2_reg, y2_reg, vx2_reg, vy2_reg;
    logic [15:0]        x1_next, y1_next, vx1_next, vy1_next;
    logic [15:0]        x2_next, y2_next, vx2_next, vy2_next;
    logic signed [23:0] kx, ky, sx, sy;
    logic signed [23:0] bx1, by1, bvx1, bvy1, bx2, by2, bvx2, bvy2;
    cec_pkg::base_t     b;

    assign b    = in_data.base;
    assign kx   = in_data.dxn ? -$signed({3'd0, in_data.kx_q}) : $signed({3'd0, in_data.kx_q});
    assign ky   = in_data.dyn ? -$signed({3'd0, in_data.ky_q}) : $signed({3'd0, in_data.ky_q});
    assign sx   = in_data.dxn ? -$signed({8'd0, in_data.sx_q}) : $signed({8'd0, in_data.sx_q});
    assign sy   = in_data.dyn ? -$signed({8'd0, in_data.sy_q}) : $signed({8'd0, in_data.sy_q});
    assign bx1  = $signed({{8{b.x1[15]}}, b.x1});
    assign by1  = $signed({{8{b.y1[15]}}, b.y1});
    assign bvx1 = $signed({{8{b.vx1[15]}}, b.vx1});
    assign bvy1 = $signed({{8{b.vy1[15]}}, b.vy1});
    assign bx2  = $signed({{8{b.x2[15]}}, b.x2});
    assign by2  = $signed({{8{b.y2[15]}}, b.y2});
    assign bvx2 = $signed({{8{b.vx2[15]}}, b.vx2});
    assign bvy2 = $signed({{8{b.vy2[15]}}, b.vy2});

    always_comb
    begin
        if (in_data.hit)
        begin
            x1_next  = cec_pkg::sat(bx1 - sx);
            y1_next  = cec_pkg::sat(by1 - sy);
            vx1_next = cec_pkg::sat(bvx1 - kx);
            vy1_next = cec_pkg::sat(bvy1 - ky);
            x2_next  = cec_pkg::sat(bx2 + sx);
            y2_next  = cec_pkg::sat(by2 + sy);
            vx2_next = cec_pkg::sat(bvx2 + kx);
            vy2_next = cec_pkg::sat(bvy2 + ky);
        end
        else
        begin
            x1_next  = b.x1;
            y1_next  = b.y1;
            vx1_next = b.vx1;
            vy1_next = b.vy1;
            x2_next  = b.x2;
            y2_next  = b.y2;
            vx2_next = b.vx2;
            vy2_next = b.vy2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= in_data.hit;
            x1_reg  <= x1_next;
            y1_reg  <= y1_next;
            vx1_reg <= vx1_next;
            vy1_reg <= vy1_next;
            x2_reg  <= x2_next;
            y2_reg  <= y2_next;
            vx2_reg <= vx2_next;
            vy2_reg <= vy2_next;
        end
    end

    assign out_valid = valid_reg;
    assign collided  = hit_reg;
    assign o_x1      = x1_reg;
    assign o_y1      = y1_reg;
    assign o_vx1     = vx1_reg;
    assign o_vy1     = vy1_reg;
    assign o_x2      = x2_reg;
    assign o_y2      = y2_reg;
    assign o_vx2     = vx2_reg;
    assign o_vy2     = vy2_reg;

endmodule

// ===== tb/circle_elastic_collision_tb.sv =====
module circle_elastic_collision_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GAP_MAX     = 11;
    localparam int DRAIN_WAIT  = 60;
    localparam int STUCK_LIMIT = 5000;

    // Slot 0 holds the collided flag; slots 1..8 the eight output words.
    typedef logic [8:0][15:0] pair_result_t;

    logic               clk;
    logic               rst_n;
    logic               valid;
    logic               stall;
    logic signed [15:0] first_x, first_y, first_vx, first_vy;
    logic [11:0]        first_radius;
    logic signed [15:0] second_x, second_y, second_vx, second_vy;
    logic [11:0]        second_radius;
    logic               result_valid;
    logic               result_stall;
    logic               collided;
    logic signed [15:0] out_first_x, out_first_y, out_first_vx, out_first_vy;
    logic signed [15:0] out_second_x, out_second_y, out_second_vx, out_second_vy;

    pair_result_t pending_results[$];
    int           mismatch_count;
    int           idle_cycles;
    bit           no_gaps;

    circle_elastic_collision i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .valid         (valid),
        .stall         (stall),
        .first_x       (first_x),
        .first_y       (first_y),
        .first_vx      (first_vx),
        .first_vy      (first_vy),
        .first_radius  (first_radius),
        .second_x      (second_x),
        .second_y      (second_y),
        .second_vx     (second_vx),
        .second_vy     (second_vy),
        .second_radius (second_radius),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .collided      (collided),
        .out_first_x   (out_first_x),
        .out_first_y   (out_first_y),
        .out_first_vx  (out_first_vx),
        .out_first_vy  (out_first_vy),
        .out_second_x  (out_second_x),
        .out_second_y  (out_second_y),
        .out_second_vx (out_second_vx),
        .out_second_vy (out_second_vy)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint round_div(longint num, longint den);
        return (num + den / 2) / den;
    endfunction

    function automatic logic [15:0] clamp_word(longint v);
        if (v > 32767)
            return 16'h7fff;
        else if (v < -32768)
            return 16'h8000;
        else
            return v[15:0];
    endfunction

    function automatic longint with_sign(longint m, longint s);
        return (s < 0) ? -m : m;
    endfunction

    function automatic pair_result_t collide_pair(
        logic signed [15:0] x1, logic signed [15:0] y1,
        logic signed [15:0] vx1, logic signed [15:0] vy1, logic [11:0] r1,
        logic signed [15:0] x2, logic signed [15:0] y2,
        logic signed [15:0] vx2, logic signed [15:0] vy2, logic [11:0] r2);
        pair_result_t res;
        longint dx, dy, dvx, dvy, rsum, dist2, dot, adot, adx, ady;
        longint root, cand, gap, kx, ky, sx, sy;
        res[0] = 16'd0;
        res[1] = x1;
        res[2] = y1;
        res[3] = vx1;
        res[4] = vy1;
        res[5] = x2;
        res[6] = y2;
        res[7] = vx2;
        res[8] = vy2;
        dx    = longint'(x2) - longint'(x1);
        dy    = longint'(y2) - longint'(y1);
        dvx   = longint'(vx2) - longint'(vx1);
        dvy   = longint'(vy2) - longint'(vy1);
        rsum  = longint'(r1) + longint'(r2);
        dist2 = dx * dx + dy * dy;
        if (dist2 == 0 || dist2 > rsum * rsum)
            return res;
        dot = dvx * dx + dvy * dy;
        if (dot > 0)
            return res;
        adot = -dot;
        adx  = (dx < 0) ? -dx : dx;
        ady  = (dy < 0) ? -dy : dy;
        kx   = with_sign(round_div(adot * adx, dist2), dx);
        ky   = with_sign(round_div(adot * ady, dist2), dy);
        root = 0;
        for (int b = 22; b >= 0; b--)
        begin
            cand = root | (longint'(1) << b);
            if (cand * cand <= (dist2 << 16))
                root = cand;
        end
        gap = (rsum << 8) > root ? (rsum << 8) - root : 0;
        sx  = with_sign(round_div(adx * gap, 2 * root), dx);
        sy  = with_sign(round_div(ady * gap, 2 * root), dy);
        res[0] = 16'd1;
        res[1] = clamp_word(longint'(x1) - sx);
        res[2] = clamp_word(longint'(y1) - sy);
        res[3] = clamp_word(longint'(vx1) - kx);
        res[4] = clamp_word(longint'(vy1) - ky);
        res[5] = clamp_word(longint'(x2) + sx);
        res[6] = clamp_word(longint'(y2) + sy);
        res[7] = clamp_word(longint'(vx2) + kx);
        res[8] = clamp_word(longint'(vy2) + ky);
        return res;
    endfunction

    task automatic send_pair(
        logic signed [15:0] x1, logic signed [15:0] y1,
        logic signed [15:0] vx1, logic signed [15:0] vy1, logic [11:0] r1,
        logic signed [15:0] x2, logic signed [15:0] y2,
        logic signed [15:0] vx2, logic signed [15:0] vy2, logic [11:0] r2);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        valid         <= 1'b1;
        first_x       <= x1;
        first_y       <= y1;
        first_vx      <= vx1;
        first_vy      <= vy1;
        first_radius  <= r1;
        second_x      <= x2;
        second_y      <= y2;
        second_vx     <= vx2;
        second_vy     <= vy2;
        second_radius <= r2;
        @(posedge clk);
        while (stall)
            @(posedge clk);
        pending_results.push_back(collide_pair(x1, y1, vx1, vy1, r1, x2, y2, vx2, vy2, r2));
    endtask

    task automatic send_random_pair(bit touching);
        logic signed [15:0] x1, y1, vx1, vy1, x2, y2, vx2, vy2;
        logic [11:0]        r1, r2;
        int                 reach;
        x1  = 16'($urandom);
        y1  = 16'($urandom);
        vx1 = 16'($urandom);
        vy1 = 16'($urandom);
        vx2 = 16'($urandom);
        vy2 = 16'($urandom);
        r1  = 12'($urandom);
        r2  = 12'($urandom);
        x2  = 16'($urandom);
        y2  = 16'($urandom);
        if (touching)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                r1 = 12'($urandom_range(0, 40));
                r2 = 12'($urandom_range(0, 40));
            end
            if ($urandom_range(0, 2) == 0)
            begin
                vx1 = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
                vy1 = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
                vx2 = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
                vy2 = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
            end
            reach = int'(r1) + int'(r2) + 4;
            x2 = x1 + 16'($urandom_range(0, 2 * reach) - reach);
            y2 = y1 + 16'($urandom_range(0, 2 * reach) - reach);
        end
        send_pair(x1, y1, vx1, vy1, r1, x2, y2, vx2, vy2, r2);
    endtask

    task automatic test_apart_and_receding;
        send_pair(0, 0, 0, 0, 100, 16'sd1000, 0, 0, 0, 100);
        send_pair(0, 0, -16'sd64, 0, 100, 16'sd150, 0, 16'sd64, 0, 100);
        send_pair(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 0,
                  16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 0);
        send_pair(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 12'hfff,
                  -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 12'hfff);
    endtask

    task automatic test_coincident_centres;
        send_pair(16'sd500, -16'sd300, 16'sd64, 0, 200, 16'sd500, -16'sd300, -16'sd64, 0, 200);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_head_on_and_tangential;
        send_pair(0, 0, 16'sd64, 0, 100, 16'sd150, 0, -16'sd64, 0, 100);
        send_pair(0, 0, 16'sd50, 16'sd30, 64, 16'sd60, 16'sd60, -16'sd20, -16'sd70, 64);
        send_pair(0, 0, 0, 16'sd64, 100, 16'sd150, 0, 0, -16'sd64, 100);
        send_pair(0, 0, 0, 0, 100, 16'sd100, 16'sd100, 0, 0, 100);
        send_pair(0, 0, 0, 0, 1, 16'sd1, 0, 0, 0, 0);
        send_pair(0, 0, 0, 0, 12'hfff, 0, -16'sd8190, 0, 0, 12'hfff);
    endtask

    task automatic test_saturation;
        send_pair(-16'sd32768, 0, 16'sd32767, 0, 12'hfff,
                  -16'sd32758, 0, -16'sd32768, 0, 12'hfff);
        send_pair(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 12'hfff,
                  16'sd32757, 16'sd32757, -16'sd32768, -16'sd32768, 12'hfff);
        send_pair(0, -16'sd32768, 0, 16'sd32767, 12'hfff,
                  0, -16'sd32767, 0, -16'sd32768, 12'hfff);
    endtask

    task automatic test_random_pairs(int count, bit steady);
        no_gaps = steady;
        for (int i = 0; i < count; i++)
            send_random_pair($urandom_range(0, 9) < 8);
        no_gaps = 1'b0;
    endtask

    always @(posedge clk)
    begin
        pair_result_t got;
        pair_result_t want;
        if (rst_n)
        begin
            if ((valid && !stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STUCK_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
        if (result_valid && !result_stall)
        begin
            got = {out_second_vy, out_second_vx, out_second_y, out_second_x,
                   out_first_vy, out_first_vx, out_first_y, out_first_x, 15'd0, collided};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat at %0t", $realtime);
            end
            else
            begin
                want = pending_results.pop_front();
                for (int f = 0; f < 9; f++)
                    if (got[f] !== want[f])
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("field %0d mismatch: expected %h, actual %h",
                                     f, want[f], got[f]);
                    end
            end
        end
    end

    int stall_left;

    always @(posedge clk)
    begin
        if (result_valid && !result_stall)
            stall_left = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
        if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else
            result_stall <= 1'b0;
    end

    initial
    begin
        mismatch_count = 0;
        idle_cycles    = 0;
        stall_left     = 0;
        no_gaps        = 1'b0;
        rst_n         <= 1'b0;
        valid         <= 1'b0;
        result_stall  <= 1'b0;
        first_x       <= '0;
        first_y       <= '0;
        first_vx      <= '0;
        first_vy      <= '0;
        first_radius  <= '0;
        second_x      <= '0;
        second_y      <= '0;
        second_vx     <= '0;
        second_vy     <= '0;
        second_radius <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_apart_and_receding();
        test_coincident_centres();
        test_head_on_and_tangential();
        test_saturation();
        test_random_pairs(1400, 1'b0);
        test_random_pairs(400, 1'b1);
        valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/cec_pkg.sv
rtl/core/cec_front.sv
rtl/core/cec_iter_step.sv
rtl/core/cec_sep_prep.sv
rtl/core/cec_sep_step.sv
rtl/core/cec_finish.sv
rtl/core/circle_elastic_collision.sv
tb/circle_elastic_collision_tb.sv
